// ===== src/bdlp_pkg.sv =====
// shared types and constants for the button debounce / long-press block
// no dependencies; imported by every module of the block
`default_nettype none

package bdlp_pkg;

   // debounce state codes
   localparam logic [2:0] ST_RELEASED = 3'd0;
   localparam logic [2:0] ST_FALLING  = 3'd1;
   localparam logic [2:0] ST_PRESSED  = 3'd2;
   localparam logic [2:0] ST_RISING   = 3'd3;
   localparam logic [2:0] ST_LONG     = 3'd4;

   // event codes
   localparam logic [1:0] EV_NONE         = 2'd0;
   localparam logic [1:0] EV_LONG_PRESS   = 2'd1;
   localparam logic [1:0] EV_SHORT_CLICK  = 2'd2;
   localparam logic [1:0] EV_LONG_RELEASE = 2'd3;

   // register indexes and reset values
   localparam logic REG_DEBOUNCE_TIME   = 1'b0;
   localparam logic REG_LONG_PRESS_TIME = 1'b1;
   localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
   } cfg_type;

   typedef struct packed {
      logic [1:0] new_event;
      logic [1:0] latched_event;
      logic [2:0] fsm_state;
   } result_type;

endpackage

`default_nettype wire

// ===== src/bdlp_csr.sv =====
// configuration registers behind the apb-style port
// depends on bdlp_pkg
`default_nettype none

module bdlp_csr
   import bdlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_DEBOUNCE_TIME:   cfg_in.debounce_time   = csr_pwdata[15:0];
            REG_LONG_PRESS_TIME: cfg_in.long_press_time = csr_pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= DEBOUNCE_RESET;
         cfg_ff.long_press_time <= LONG_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_DEBOUNCE_TIME:   csr_prdata = {16'd0, cfg_ff.debounce_time};
         REG_LONG_PRESS_TIME: csr_prdata = {16'd0, cfg_ff.long_press_time};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/bdlp_fsm.sv =====
// debounce / long-press state machine with event latch
// depends on bdlp_pkg
`default_nettype none

module bdlp_fsm
   import bdlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        pressed,
   input  wire logic [31:0] now_ms,
   input  wire logic        take_event,
   input  cfg_type          cfg,
   output result_type       result
);

   logic [2:0]  state_ff, state_in;
   logic [31:0] edge_start_ff, edge_start_in;
   logic [31:0] press_start_ff, press_start_in;
   logic [1:0]  pending_ff, pending_in;
   logic [1:0]  ev;
   logic [1:0]  latched;
   logic [31:0] edge_elapsed;
   logic [31:0] press_elapsed;
   logic        debounce_done;
   logic        long_done;

   assign edge_elapsed  = now_ms - edge_start_ff;
   assign press_elapsed = now_ms - press_start_ff;
   assign debounce_done = edge_elapsed >= {16'd0, cfg.debounce_time};
   assign long_done     = press_elapsed >= {16'd0, cfg.long_press_time};

   always_comb begin
      state_in       = state_ff;
      edge_start_in  = edge_start_ff;
      press_start_in = press_start_ff;
      ev             = EV_NONE;
      case (state_ff)
         ST_FALLING: begin
            if (!pressed) begin
               state_in = ST_RELEASED;
            end else if (debounce_done) begin
               state_in       = ST_PRESSED;
               press_start_in = now_ms;
            end
         end
         ST_PRESSED: begin
            if (!pressed) begin
               state_in      = ST_RISING;
               edge_start_in = now_ms;
            end else if (long_done) begin
               state_in = ST_LONG;
               ev       = EV_LONG_PRESS;
            end
         end
         ST_RISING: begin
            // bounce back keeps the original press time
            if (pressed) begin
               state_in = ST_PRESSED;
            end else if (debounce_done) begin
               state_in = ST_RELEASED;
               ev       = EV_SHORT_CLICK;
            end
         end
         ST_LONG: begin
            if (!pressed) begin
               state_in = ST_RELEASED;
               ev       = EV_LONG_RELEASE;
            end
         end
         default: begin
            state_in = ST_RELEASED;
            if (pressed) begin
               state_in      = ST_FALLING;
               edge_start_in = now_ms;
            end
         end
      endcase
   end

   assign latched    = (ev != EV_NONE) ? ev : pending_ff;
   assign pending_in = take_event ? EV_NONE : latched;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RELEASED;
         edge_start_ff  <= 32'd0;
         press_start_ff <= 32'd0;
         pending_ff     <= EV_NONE;
      end else if (step) begin
         state_ff       <= state_in;
         edge_start_ff  <= edge_start_in;
         press_start_ff <= press_start_in;
         pending_ff     <= pending_in;
      end
   end

   assign result.new_event     = ev;
   assign result.latched_event = latched;
   assign result.fsm_state     = state_in;

endmodule

`default_nettype wire

// ===== src/button_debounce_long_press_top.sv =====
// request register, then result register; a stall on the result channel holds a
// request in the first; one request per cycle sustained while results are taken,
// with the combinational state machine update between the two registers
// synchronous active-high reset empties both registers, returns the machine to
// released with no latched event, and loads debounce 20 ms and long press 1000 ms
// depends on bdlp_pkg, bdlp_csr, bdlp_fsm
`default_nettype none

module button_debounce_long_press_top
   import bdlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_pressed,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        req_take_event,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [1:0]  rsp_new_event,
   output logic      [1:0]  rsp_latched_event,
   output logic      [2:0]  rsp_fsm_state,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg;
   result_type result;

   // request register
   logic        req_valid_ff;
   logic        req_pressed_ff;
   logic [31:0] req_now_ms_ff;
   logic        req_take_ff;

   // result register
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   // the held request moves into the result register when that is free or draining
   logic advance;
   logic req_fire;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_pressed_ff <= req_pressed;
         req_now_ms_ff  <= req_now_ms;
         req_take_ff    <= req_take_event;
      end
   end

   bdlp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // state machine commits only when its result is captured
   bdlp_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .pressed    (req_pressed_ff),
      .now_ms     (req_now_ms_ff),
      .take_event (req_take_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_event     = rsp_ff.new_event;
   assign rsp_latched_event = rsp_ff.latched_event;
   assign rsp_fsm_state     = rsp_ff.fsm_state;

`ifndef SYNTHESIS
   // a raised event is always the latched one in the same result
   a_event_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_new_event != EV_NONE) |-> rsp_latched_event == rsp_new_event)
      else $error("raised event not latched");

   // a long press leaves the machine in the long-press state
   a_long_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_new_event == EV_LONG_PRESS) |-> rsp_fsm_state == ST_LONG)
      else $error("long press without long state");

   // click and long release both end in released
   a_release_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_new_event == EV_SHORT_CLICK) ||
                    (rsp_new_event == EV_LONG_RELEASE)) |-> rsp_fsm_state == ST_RELEASED)
      else $error("release event without released state");

   // a held request that cannot move on blocks new requests
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |-> !req_ready)
      else $error("request register overrun");
`endif

endmodule

`default_nettype wire
